/* rtl/pcs_pkg.sv */
// shared types and arithmetic for the polyline corner cut smoother
// point and token structs, corner cut helper; no dependencies
package pcs_pkg;

  localparam int CoordBits = 32;

  typedef logic [CoordBits-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  // one point travelling down the row of cells
  typedef struct packed {
    point_t     pt;
    logic       first;
    logic       last;
    logic       closed;
    logic       drop;
    logic [1:0] passes;
  } tok_t;

  // floor((3a + b) / 4), exact; the result lies between a and b
  function automatic coord_t cut(input coord_t a, input coord_t b);
    logic signed [CoordBits+1:0] sa;
    logic signed [CoordBits+1:0] sb;
    logic signed [CoordBits+1:0] s;
    sa = {{2{a[CoordBits-1]}}, a};
    sb = {{2{b[CoordBits-1]}}, b};
    s  = sa + (sa <<< 1) + sb;
    return s[CoordBits+1:2];
  endfunction

  function automatic point_t cut_pt(input point_t a, input point_t b);
    point_t r;
    r.x = cut(a.x, b.x);
    r.y = cut(a.y, b.y);
    r.z = cut(a.z, b.z);
    return r;
  endfunction

endpackage

/* rtl/pcs_front.sv */
// chain front end: holds the first two points until the chain length is known
// and issues tokens to the first cell; uses pcs_pkg
module pcs_front #(
  parameter int MAX_PASSES = 3
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [1:0]      cfg_passes,
  input  logic            in_valid,
  output logic            in_ready,
  input  pcs_pkg::point_t in_pt,
  input  logic            in_loop,
  input  logic            in_end,
  output logic            tok_valid,
  input  logic            tok_ready,
  output pcs_pkg::tok_t   tok
);

  typedef enum logic [1:0] {M_PAIR, M_THIRD, M_NEXT} mode_t;

  logic            busy_r, busy_nxt;
  mode_t           mode_r, mode_nxt;
  logic [1:0]      ph_r, ph_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic            closed_r, closed_nxt;
  logic [1:0]      passes_r, passes_nxt;
  logic            drop_r, drop_nxt;
  logic            end_r, end_nxt;
  pcs_pkg::point_t cur_r, cur_nxt;
  pcs_pkg::point_t h0_r, h0_nxt;
  pcs_pkg::point_t h1_r, h1_nxt;

  logic       tok_last;
  logic       fire;
  logic       done;
  logic       accept;
  logic [1:0] clamp;
  logic       full;

  // pass count clamp
  always_comb begin
    full  = int'(cfg_passes) >= MAX_PASSES;
    clamp = full ? 2'(MAX_PASSES) : cfg_passes;
  end

  // handshake
  always_comb begin
    case (mode_r)
      M_PAIR:  tok_last = (ph_r == 2'd1);
      M_THIRD: tok_last = (ph_r == 2'd2);
      default: tok_last = 1'b1;
    endcase
  end

  assign fire      = busy_r && tok_ready;
  assign done      = fire && tok_last;
  assign in_ready  = !busy_r || done;
  assign accept    = in_valid && in_ready;
  assign tok_valid = busy_r;

  // token selection
  always_comb begin
    tok.pt     = cur_r;
    tok.first  = 1'b0;
    tok.last   = end_r;
    tok.closed = closed_r;
    tok.drop   = drop_r;
    tok.passes = passes_r;
    case (mode_r)
      M_PAIR: begin
        tok.pt     = (ph_r == 2'd0) ? h0_r : cur_r;
        tok.first  = (ph_r == 2'd0);
        tok.last   = (ph_r == 2'd1);
        tok.closed = 1'b0;
        tok.drop   = 1'b0;
        tok.passes = 2'd0;
      end
      M_THIRD: begin
        case (ph_r)
          2'd0:    tok.pt = h0_r;
          2'd1:    tok.pt = h1_r;
          default: tok.pt = cur_r;
        endcase
        tok.first = (ph_r == 2'd0);
        tok.last  = (ph_r == 2'd2) && end_r;
      end
      default: begin
        tok.pt = cur_r;
      end
    endcase
  end

  // chain tracking
  always_comb begin
    busy_nxt   = busy_r;
    mode_nxt   = mode_r;
    ph_nxt     = ph_r;
    cnt_nxt    = cnt_r;
    closed_nxt = closed_r;
    passes_nxt = passes_r;
    drop_nxt   = drop_r;
    end_nxt    = end_r;
    cur_nxt    = cur_r;
    h0_nxt     = h0_r;
    h1_nxt     = h1_r;
    if (done) begin
      busy_nxt = 1'b0;
      ph_nxt   = 2'd0;
    end else if (fire) begin
      ph_nxt = ph_r + 2'd1;
    end
    if (accept) begin
      cur_nxt = in_pt;
      end_nxt = in_end;
      ph_nxt  = 2'd0;
      case (cnt_r)
        2'd0: begin
          closed_nxt = in_loop;
          if (!in_end) begin
            h0_nxt  = in_pt;
            cnt_nxt = 2'd1;
          end
        end
        2'd1: begin
          if (in_end) begin
            busy_nxt = 1'b1;
            mode_nxt = M_PAIR;
            cnt_nxt  = 2'd0;
          end else begin
            h1_nxt  = in_pt;
            cnt_nxt = 2'd2;
          end
        end
        2'd2: begin
          busy_nxt   = 1'b1;
          mode_nxt   = M_THIRD;
          passes_nxt = clamp;
          drop_nxt   = in_end && closed_r && full;
          cnt_nxt    = in_end ? 2'd0 : 2'd3;
        end
        default: begin
          busy_nxt = 1'b1;
          mode_nxt = M_NEXT;
          cnt_nxt  = in_end ? 2'd0 : 2'd3;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      mode_r   <= M_NEXT;
      ph_r     <= 2'd0;
      cnt_r    <= 2'd0;
      closed_r <= 1'b0;
      passes_r <= 2'd0;
      drop_r   <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      mode_r   <= mode_nxt;
      ph_r     <= ph_nxt;
      cnt_r    <= cnt_nxt;
      closed_r <= closed_nxt;
      passes_r <= passes_nxt;
      drop_r   <= drop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    end_r <= end_nxt;
    cur_r <= cur_nxt;
    h0_r  <= h0_nxt;
    h1_r  <= h1_nxt;
  end

endmodule

/* rtl/pcs_cell.sv */
// one corner cutting pass: each incoming point yields up to four points
// uses pcs_pkg
module pcs_cell #(
  parameter int STAGE = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  pcs_pkg::tok_t in_tok,
  output logic          out_valid,
  input  logic          out_ready,
  output pcs_pkg::tok_t out_tok
);

  logic            v_r, v_nxt;
  logic [1:0]      ph_r, ph_nxt;
  logic            st_r, st_nxt;
  pcs_pkg::tok_t   t_r, t_nxt;
  pcs_pkg::point_t a_r, a_nxt;
  pcs_pkg::point_t f_r, f_nxt;

  logic       active;
  logic [2:0] n;
  logic       emit;
  logic       retire;
  logic       accept;

  // number of points this token produces
  always_comb begin
    active = int'(t_r.passes) > STAGE;
    if (!active) begin
      n = 3'd1;
    end else if (t_r.first) begin
      n = t_r.closed ? 3'd0 : 3'd1;
    end else if (t_r.last) begin
      n = t_r.closed ? 3'd4 : 3'd3;
    end else begin
      n = 3'd2;
    end
  end

  assign out_valid = v_r && (n != 3'd0);
  assign emit      = out_valid && out_ready;
  assign retire    = v_r && ((n == 3'd0) || (out_ready && ({1'b0, ph_r} == n - 3'd1)));
  assign in_ready  = !v_r || retire;
  assign accept    = in_valid && in_ready;

  // output point by phase
  always_comb begin
    out_tok       = t_r;
    out_tok.first = active ? !st_r : t_r.first;
    out_tok.last  = t_r.last && ({1'b0, ph_r} == n - 3'd1);
    if (active && !t_r.first) begin
      case (ph_r)
        2'd0:    out_tok.pt = pcs_pkg::cut_pt(a_r, t_r.pt);
        2'd1:    out_tok.pt = pcs_pkg::cut_pt(t_r.pt, a_r);
        2'd2:    out_tok.pt = t_r.closed ? pcs_pkg::cut_pt(t_r.pt, f_r) : t_r.pt;
        default: out_tok.pt = pcs_pkg::cut_pt(f_r, t_r.pt);
      endcase
    end
  end

  // token intake and phase
  always_comb begin
    v_nxt  = v_r;
    ph_nxt = ph_r;
    st_nxt = st_r;
    t_nxt  = t_r;
    a_nxt  = a_r;
    f_nxt  = f_r;
    if (retire) begin
      v_nxt  = 1'b0;
      ph_nxt = 2'd0;
    end else if (emit) begin
      ph_nxt = ph_r + 2'd1;
    end
    if (emit && active) begin
      st_nxt = 1'b1;
    end
    if (accept) begin
      v_nxt  = 1'b1;
      ph_nxt = 2'd0;
      t_nxt  = in_tok;
      if (in_tok.first) begin
        f_nxt  = in_tok.pt;
        a_nxt  = in_tok.pt;
        st_nxt = 1'b0;
      end else begin
        a_nxt = t_r.pt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= 1'b0;
      ph_r <= 2'd0;
      st_r <= 1'b0;
    end else begin
      v_r  <= v_nxt;
      ph_r <= ph_nxt;
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r <= t_nxt;
    a_r <= a_nxt;
    f_r <= f_nxt;
  end

endmodule

/* rtl/pcs_emit.sv */
// result stage: repeats the first point at the end of a closed chain unless drop is set
// uses pcs_pkg
module pcs_emit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  pcs_pkg::tok_t   in_tok,
  output logic            out_valid,
  input  logic            out_ready,
  output pcs_pkg::point_t out_pt,
  output logic            out_last
);

  logic            v_r, v_nxt;
  logic            ph_r, ph_nxt;
  logic            fov_r, fov_nxt;
  pcs_pkg::tok_t   t_r, t_nxt;
  pcs_pkg::point_t fo_r, fo_nxt;

  logic two;
  logic retire;
  logic accept;

  // closing point follows the last point of a closed chain unless drop is set
  assign two       = t_r.last && t_r.closed && !t_r.drop;
  assign out_valid = v_r;
  assign out_pt    = ph_r ? fo_r : t_r.pt;
  assign out_last  = two ? ph_r : t_r.last;
  assign retire    = v_r && out_ready && (!two || ph_r);
  assign in_ready  = !v_r || retire;
  assign accept    = in_valid && in_ready;

  always_comb begin
    v_nxt   = v_r;
    ph_nxt  = ph_r;
    fov_nxt = fov_r;
    t_nxt   = t_r;
    fo_nxt  = fo_r;
    if (retire) begin
      v_nxt  = 1'b0;
      ph_nxt = 1'b0;
    end else if (v_r && out_ready) begin
      ph_nxt = 1'b1;
    end
    if (accept) begin
      v_nxt  = 1'b1;
      ph_nxt = 1'b0;
      t_nxt  = in_tok;
      if (!fov_r) begin
        fo_nxt  = in_tok.pt;
        fov_nxt = !in_tok.last;
      end else if (in_tok.last) begin
        fov_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= 1'b0;
      ph_r  <= 1'b0;
      fov_r <= 1'b0;
    end else begin
      v_r   <= v_nxt;
      ph_r  <= ph_nxt;
      fov_r <= fov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r  <= t_nxt;
    fo_r <= fo_nxt;
  end

endmodule

/* rtl/polyline_corner_cut_smoother.sv */
// top level of the polyline corner cut smoother
// front end, a row of pass cells and the result stage; uses pcs_pkg
//
//   channel  dir  payload                              handshake
//   in_      in   tdata x,y,z; tuser loop; tlast end   tvalid/tready
//   out_     out  tdata x,y,z; tlast end               tvalid/tready
//   cfg_     in   wdata pass count                     we
//
// every cell works on its own point while the others do, and each moves one
// point a cycle when not stalled; a middle point yields 2^passes results, up
// to 8 at three passes. the third point releases the start of the chain, up to
// 24 results, and the last point up to 23 with the repeated closing point.
// the third point of a chain issues three tokens to the first cell.
// reset is synchronous and clears only control state; either side may stall
// at any time, and a stall backs up through the row of cells to in_tready.
module polyline_corner_cut_smoother #(
  parameter int MAX_PASSES = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // in_x, in_y, in_z
  input  logic        in_tuser,   // loop_chain
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // out_x, out_y, out_z
  output logic        out_tlast
);

  logic [1:0]      passes_r;
  pcs_pkg::point_t in_pt;
  pcs_pkg::point_t res_pt;

  pcs_pkg::tok_t tok   [MAX_PASSES+1];
  logic          tvld  [MAX_PASSES+1];
  logic          trdy  [MAX_PASSES+1];

  // pass count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      passes_r <= 2'd3;
    end else if (cfg_we) begin
      passes_r <= cfg_wdata;
    end
  end

  assign in_pt.x = in_tdata[31:0];
  assign in_pt.y = in_tdata[63:32];
  assign in_pt.z = in_tdata[95:64];

  pcs_front #(.MAX_PASSES(MAX_PASSES)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_passes (passes_r),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_pt      (in_pt),
    .in_loop    (in_tuser),
    .in_end     (in_tlast),
    .tok_valid  (tvld[0]),
    .tok_ready  (trdy[0]),
    .tok        (tok[0])
  );

  // one cell per pass
  for (genvar s = 0; s < MAX_PASSES; s++) begin : g_cell
    pcs_cell #(.STAGE(s)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (tvld[s]),
      .in_ready  (trdy[s]),
      .in_tok    (tok[s]),
      .out_valid (tvld[s+1]),
      .out_ready (trdy[s+1]),
      .out_tok   (tok[s+1])
    );
  end

  pcs_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (tvld[MAX_PASSES]),
    .in_ready  (trdy[MAX_PASSES]),
    .in_tok    (tok[MAX_PASSES]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_pt    (res_pt),
    .out_last  (out_tlast)
  );

  assign out_tdata = {res_pt.z, res_pt.y, res_pt.x};

endmodule
